>>> sv/cfhd_pkg.sv
// ----------------------------------------------------------------------------
// cfhd_pkg
// Shared constants and control types for the circular frame header deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfhd_pkg;

  // Block geometry
  localparam int unsigned BLOCK_LEN = 21;
  localparam int unsigned CNT_W     = $clog2(BLOCK_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

  // Header pattern, first byte on the wire first
  localparam logic [7:0] HDR0 = 8'hFF;
  localparam logic [7:0] HDR1 = 8'h55;
  localparam logic [7:0] HDR2 = 8'hAA;
  localparam logic [7:0] HDR3 = 8'h10;

  // Payload geometry
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NUM_WORDS = 3;
  localparam int unsigned HDR_LEN = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic shift_en;    // advance the byte ring one place
    logic load_byte;   // ring input takes the received byte, else recirculates
    logic scan_en;     // test the header taps, capture payload on a hit
    logic clear_found; // start of a new search
    logic load_out;    // copy found flag and held words to the output stage
  } cfhd_cmd_t;

endpackage

`default_nettype wire

>>> sv/cfhd_datapath.sv
// ----------------------------------------------------------------------------
// cfhd_datapath
// Byte ring, header comparator, held payload words and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfhd_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cfhd_pkg::cfhd_cmd_t       cmd_i,
  input  wire logic [7:0]                rx_byte_i,
  output logic                           out_found_o,
  output logic [cfhd_pkg::WORD_W-1:0]    out_y_o,
  output logic [cfhd_pkg::WORD_W-1:0]    out_x_o,
  output logic [cfhd_pkg::WORD_W-1:0]    out_z_o
);
  import cfhd_pkg::*;

  logic [7:0]        buf_q [BLOCK_LEN];
  logic [7:0]        ring_in;
  logic              match;
  logic              found_q;
  logic [WORD_W-1:0] held_y_q, held_x_q, held_z_q;
  logic [WORD_W-1:0] tap_y, tap_x, tap_z;

  // Ring input: new byte while filling, oldest byte while scanning
  assign ring_in = cmd_i.load_byte ? rx_byte_i : buf_q[0];

  // Ring shifts toward index 0; after a full block index 0 holds the first
  // byte, and each scan step rotates the next start position into place
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      for (int i = 0; i < BLOCK_LEN - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[BLOCK_LEN-1] <= ring_in;
    end
  end

  // Header test at the fixed taps 0..3
  assign match = (buf_q[0] == HDR0) && (buf_q[1] == HDR1) &&
                 (buf_q[2] == HDR2) && (buf_q[3] == HDR3);

  // Little-endian payload words at the taps after the header
  assign tap_y = {buf_q[HDR_LEN+3], buf_q[HDR_LEN+2], buf_q[HDR_LEN+1], buf_q[HDR_LEN]};
  assign tap_x = {buf_q[HDR_LEN+7], buf_q[HDR_LEN+6], buf_q[HDR_LEN+5], buf_q[HDR_LEN+4]};
  assign tap_z = {buf_q[HDR_LEN+11], buf_q[HDR_LEN+10], buf_q[HDR_LEN+9], buf_q[HDR_LEN+8]};

  // Held words: a later hit overwrites an earlier one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      held_y_q <= '0;
      held_x_q <= '0;
      held_z_q <= '0;
    end else begin
      if (cmd_i.clear_found) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_en && match) begin
        found_q <= 1'b1;
      end
      if (cmd_i.scan_en && match) begin
        held_y_q <= tap_y;
        held_x_q <= tap_x;
        held_z_q <= tap_z;
      end
    end
  end

  // Output stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_found_o <= found_q;
      out_y_o     <= held_y_q;
      out_x_o     <= held_x_q;
      out_z_o     <= held_z_q;
    end
  end

endmodule

`default_nettype wire

>>> sv/cfhd_ctrl.sv
// ----------------------------------------------------------------------------
// cfhd_ctrl
// Sequencer: fills a block, steps the circular search, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cfhd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cfhd_pkg::cfhd_cmd_t      cmd_o
);
  import cfhd_pkg::*;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             in_beat;
  logic             slot_free;

  assign in_ready_o  = (state_q == ST_FILL);
  assign in_beat     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Commands decoded from state
  always_comb begin
    cmd_o             = '0;
    cmd_o.load_byte   = (state_q == ST_FILL);
    cmd_o.shift_en    = in_beat || (state_q == ST_SCAN);
    cmd_o.scan_en     = (state_q == ST_SCAN);
    cmd_o.clear_found = in_beat && (cnt_q == CNT_LAST);
    cmd_o.load_out    = (state_q == ST_DONE) && slot_free;
  end

  // State, position counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_FILL: begin
          if (in_beat) begin
            if (cnt_q == CNT_LAST) begin
              cnt_q   <= '0;
              state_q <= ST_SCAN;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (cnt_q == CNT_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_q <= ST_FILL;
          end
        end
        default: state_q <= ST_FILL;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Position counter never leaves the block
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LAST)
    else $error("position counter out of range");

  // A result is loaded only into a free output stage
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending beat");

  // The last byte of a block starts the search on the next cycle
  a_fill_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && cnt_q == CNT_LAST) |=> (state_q == ST_SCAN && cnt_q == '0))
    else $error("search did not start after a full block");

  // No byte is taken while searching
  a_no_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_en |-> !in_ready_o)
    else $error("input accepted during search");
`endif

endmodule

`default_nettype wire

>>> sv/circular_frame_header_deframer.sv
// ----------------------------------------------------------------------------
// circular_frame_header_deframer
// Collects bytes into blocks, finds the FF 55 AA 10 header at any circular
// position (last hit wins) and emits one beat per block with the payload.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser
//  s_axis    in   rx_byte[7:0]                   -
//  m_axis    out  value_y, value_x, value_z      header_found
//
//  A block of BLOCK_LEN bytes is taken in as fill beats, then searched
//  position by position on the rotating byte ring, then its result is
//  handed off to the output stage. Input is held off during search and
//  while a finished result waits for a free output stage. Reset clears the
//  sequencer and the held words to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_frame_header_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [95:0]      m_axis_tdata_o,   // [31:0] value_y, [63:32] value_x,
                                             // [95:64] value_z
  output logic             m_axis_tuser_o    // [0] header_found
);
  import cfhd_pkg::*;

  cfhd_cmd_t         cmd;
  logic [WORD_W-1:0] out_y, out_x, out_z;

  cfhd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  cfhd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rx_byte_i   (s_axis_tdata_i),
    .out_found_o (m_axis_tuser_o),
    .out_y_o     (out_y),
    .out_x_o     (out_x),
    .out_z_o     (out_z)
  );

  assign m_axis_tdata_o = {out_z, out_x, out_y};

endmodule

`default_nettype wire

>>> bench/tb_circular_frame_header_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_frame_header_deframer
// Self-checking bench for the block header deframer. Bytes are streamed in,
// and a local model of the block buffer computes the result beat that each
// full block should yield. Results are checked field by field in order.
// Traffic covers headers at every kind of position, wrapped and overlapping
// headers, near misses and blocks split across a pause, under several
// source-idle and sink-stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_frame_header_deframer;
  import cfhd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 3 * BLOCK_LEN;
  localparam int unsigned RANDOM_BLOCKS  = 17;   // per idle mix
  localparam int unsigned MAX_PRINTS     = 30;

  // One result beat as the block should present it
  typedef struct {
    logic        found;
    logic [31:0] y;
    logic [31:0] x;
    logic [31:0] z;
  } deframe_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;   // [31:0] value_y, [63:32] value_x, [95:64] value_z
  logic        m_axis_tuser_o;   // [0] header_found

  circular_frame_header_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model state: byte ring, fill level and held payload words
  logic [7:0]  model_ring [BLOCK_LEN];
  int unsigned model_fill;
  logic [31:0] model_held [NUM_WORDS];

  deframe_result_t results_pending[$];

  // Block under construction for the stimulus
  logic [7:0]  block_bytes [BLOCK_LEN];

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned found_seen     = 0;
  int unsigned idle_cycles    = 0;

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] ring_word(int unsigned pos);
    logic [31:0] w;
    w = '0;
    for (int unsigned k = 0; k < 4; k++)
      w[8*k +: 8] = model_ring[(pos + k) % BLOCK_LEN];
    return w;
  endfunction

  // Take one accepted byte; on a full block scan and queue the result
  task automatic deframe_byte(input logic [7:0] b);
    deframe_result_t r;
    int unsigned     head;
    logic            hit;
    head = 0;
    hit  = 1'b0;
    model_ring[model_fill] = b;
    model_fill++;
    if (model_fill == BLOCK_LEN) begin
      model_fill = 0;
      // last matching start position wins
      for (int unsigned m = 0; m < BLOCK_LEN; m++) begin
        if (model_ring[m] == HDR0 && model_ring[(m + 1) % BLOCK_LEN] == HDR1 &&
            model_ring[(m + 2) % BLOCK_LEN] == HDR2 &&
            model_ring[(m + 3) % BLOCK_LEN] == HDR3) begin
          head = m;
          hit  = 1'b1;
        end
      end
      if (hit) begin
        for (int unsigned i = 0; i < NUM_WORDS; i++)
          model_held[i] = ring_word(head + HDR_LEN + 4 * i);
      end
      r.found = hit;
      r.y     = model_held[0];
      r.x     = model_held[1];
      r.z     = model_held[2];
      results_pending.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    deframe_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (results_pending.size() == 0) begin
        report_mismatch("unexpected result beat", {31'b0, m_axis_tuser_o}, 32'h0);
      end else begin
        want = results_pending.pop_front();
        if (want.found) found_seen++;
        if (m_axis_tuser_o !== want.found)
          report_mismatch("header_found", {31'b0, m_axis_tuser_o}, {31'b0, want.found});
        if (m_axis_tdata_o[31:0] !== want.y)
          report_mismatch("value_y", m_axis_tdata_o[31:0], want.y);
        if (m_axis_tdata_o[63:32] !== want.x)
          report_mismatch("value_x", m_axis_tdata_o[63:32], want.x);
        if (m_axis_tdata_o[95:64] !== want.z)
          report_mismatch("value_z", m_axis_tdata_o[95:64], want.z);
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("** circular_frame_header_deframer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sink back-pressure
  always @(negedge clk_i)
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic send_block_range(input int unsigned first, input int unsigned last);
    for (int unsigned i = first; i <= last; i++) send_byte(block_bytes[i]);
  endtask

  task automatic send_block();
    send_block_range(0, BLOCK_LEN - 1);
  endtask

  task automatic fill_block(input logic [7:0] v);
    for (int unsigned i = 0; i < BLOCK_LEN; i++) block_bytes[i] = v;
  endtask

  // Filler leaning toward header bytes so near misses show up
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(9))
      0: return HDR0;
      1: return HDR1;
      2: return HDR2;
      3: return HDR3;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] payload_word();
    case ($urandom_range(9))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic plant_header(input int unsigned pos);
    block_bytes[pos % BLOCK_LEN]       = HDR0;
    block_bytes[(pos + 1) % BLOCK_LEN] = HDR1;
    block_bytes[(pos + 2) % BLOCK_LEN] = HDR2;
    block_bytes[(pos + 3) % BLOCK_LEN] = HDR3;
  endtask

  task automatic plant_word(input int unsigned pos, input logic [31:0] w);
    for (int unsigned k = 0; k < 4; k++)
      block_bytes[(pos + k) % BLOCK_LEN] = w[8*k +: 8];
  endtask

  // Header plus its three payload words, all wrapping as needed
  task automatic plant_frame(input int unsigned pos, input logic [31:0] wy,
                             input logic [31:0] wx, input logic [31:0] wz);
    plant_header(pos);
    plant_word(pos + 4, wy);
    plant_word(pos + 8, wx);
    plant_word(pos + 12, wz);
  endtask

  task automatic set_mix(input int unsigned src, input int unsigned sink);
    src_idle_pct   = src;
    sink_stall_pct = sink;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_blocks();
    // no header right after reset: held words still zero
    fill_block(8'h00);
    send_block();
    // header at the start, payload extremes
    fill_block(8'h00);
    plant_frame(0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001);
    send_block();
    // all ones, no header: previous words held
    fill_block(8'hFF);
    send_block();
    // payload wraps to the buffer start
    fill_block(8'h00);
    plant_frame(17, 32'h3F80_0000, 32'hC049_0FDB, 32'h7F7F_FFFF);
    send_block();
    // header itself wraps
    fill_block(8'h5A);
    plant_frame(19, $urandom, $urandom, $urandom);
    send_block();
    // header at the last position
    fill_block(8'hA5);
    plant_frame(BLOCK_LEN - 1, $urandom, $urandom, $urandom);
    send_block();
    // two frames: the second overwrites the first header, so only it remains
    fill_block(8'h00);
    plant_frame(2, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
    plant_frame(10, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666);
    send_block();
    // near miss: last header byte off by one
    fill_block(8'h00);
    plant_header(5);
    block_bytes[8] = HDR3 + 8'h01;
    send_block();
    stop_input();
  endtask

  // Half a block, then a pause with nothing outstanding, then the rest
  task automatic test_split_block_pause();
    for (int unsigned i = 0; i < BLOCK_LEN; i++) block_bytes[i] = noise_byte();
    plant_frame($urandom_range(BLOCK_LEN - 1), payload_word(), payload_word(),
                payload_word());
    send_block_range(0, BLOCK_LEN / 2 - 1);
    stop_input();
    while (results_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    send_block_range(BLOCK_LEN / 2, BLOCK_LEN - 1);
    stop_input();
  endtask

  task automatic test_random_blocks(input int unsigned nblocks);
    int unsigned kind;
    int unsigned pos;
    for (int unsigned n = 0; n < nblocks; n++) begin
      kind = $urandom_range(99);
      for (int unsigned i = 0; i < BLOCK_LEN; i++) block_bytes[i] = noise_byte();
      if (kind < 55) begin
        plant_frame($urandom_range(BLOCK_LEN - 1), payload_word(), payload_word(),
                    payload_word());
      end else if (kind < 70) begin
        plant_frame($urandom_range(BLOCK_LEN - 1), payload_word(), payload_word(),
                    payload_word());
        plant_header($urandom_range(BLOCK_LEN - 1));
      end else if (kind < 85) begin
        // broken header: one of its bytes flipped
        pos = $urandom_range(BLOCK_LEN - 1);
        plant_frame(pos, payload_word(), payload_word(), payload_word());
        block_bytes[(pos + $urandom_range(3)) % BLOCK_LEN] ^= 8'($urandom_range(255, 1));
      end
      send_block();
    end
    stop_input();
  endtask

  // Trailing bytes that never complete a block yield nothing
  task automatic test_trailing_partial();
    for (int unsigned i = 0; i < 7; i++) send_byte(noise_byte());
    stop_input();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    model_fill = 0;
    for (int unsigned i = 0; i < NUM_WORDS; i++) model_held[i] = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_mix(0, 0);
    test_directed_blocks();
    test_split_block_pause();

    set_mix(0, 0);
    test_random_blocks(RANDOM_BLOCKS);
    set_mix(69, 0);
    test_random_blocks(RANDOM_BLOCKS);
    set_mix(0, 69);
    test_random_blocks(RANDOM_BLOCKS);
    set_mix(34, 34);
    test_random_blocks(RANDOM_BLOCKS);
    test_split_block_pause();
    test_trailing_partial();

    while (results_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d block results, %0d with a header found,",
             bytes_sent, results_seen, found_seen);
    $display("over idle-free, source-idle, sink-stall and mixed traffic.");
    if (error_count == 0 && results_pending.size() == 0) begin
      $display("** circular_frame_header_deframer: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               results_pending.size());
      $display("** circular_frame_header_deframer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
